/* design/grow_on_collision_hash_table_macros.svh */
// Assertion macros for the grow-on-collision hash table.
// Used by the top level only; no other dependencies.
`ifndef GROW_ON_COLLISION_HASH_TABLE_MACROS_SVH
`define GROW_ON_COLLISION_HASH_TABLE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define GCHT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GCHT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/gcht_pkg.sv */
// Shared types and constants of the grow-on-collision hash table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gcht_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int HASH_W      = 32;
   localparam int VAL_W       = 32;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CAP_W       = 11;
   localparam int ADDR_W      = IDX_W + 1;
   localparam int DEPTH       = 2 * MAX_ENTRIES;
   localparam int CNT_W       = $clog2(HASH_W);

   localparam logic       ACT_INSERT = 1'b0;
   localparam logic       ACT_LOOKUP = 1'b1;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_FOUND     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   localparam logic [2:0] REG_INIT_CAP = 3'd0;

   typedef struct packed {
      logic              action;
      logic [HASH_W-1:0] key_hash;
      logic [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [VAL_W-1:0] value_out;
      logic [CAP_W-1:0] capacity_now;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
      logic [VAL_W-1:0]  value;
   } entry_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } ram_wr_type;

   typedef struct packed {
      logic              re;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] dividend;
      logic [CAP_W-1:0]  divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] rem;
   } mod_rsp_type;

endpackage

/* design/gcht_mod_unit.sv */
// Remainder unit: key hash modulo slot count, one bit per cycle,
// with a registered mask path for power-of-two counts. Uses gcht_pkg.
`timescale 1ns / 1ps

module gcht_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  gcht_pkg::mod_req_type mod_req,
   output gcht_pkg::mod_rsp_type mod_rsp
);
   import gcht_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [HASH_W-1:0] dvd_ff, dvd_in;
   logic [CAP_W-1:0]  div_ff, div_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [CAP_W-1:0]  mask;
   logic [CAP_W-1:0]  trial;
   logic [CAP_W-1:0]  diff;

   assign mask  = mod_req.divisor - CAP_W'(1);
   assign trial = {rem_ff, dvd_ff[HASH_W-1]};
   assign diff  = trial - div_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (mod_req.start) begin
         div_in = mod_req.divisor;
         if ((mod_req.divisor & mask) == '0) begin
            rem_in  = mod_req.dividend[IDX_W-1:0] & mask[IDX_W-1:0];
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            dvd_in  = mod_req.dividend;
            rem_in  = '0;
         end
      end else if (busy_ff) begin
         rem_in = (trial >= div_ff) ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
         dvd_in = {dvd_ff[HASH_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(HASH_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign mod_rsp.done = done_ff;
   assign mod_rsp.rem  = rem_ff;

endmodule

/* design/gcht_slot_ram.sv */
// Slot memory: two banks of entries, one write and one registered read
// per cycle. Uses gcht_pkg.
`timescale 1ns / 1ps

module gcht_slot_ram (
   input  logic                clock,
   input  gcht_pkg::ram_wr_type ram_wr,
   input  gcht_pkg::ram_rd_type ram_rd,
   output gcht_pkg::entry_type  rdata
);
   import gcht_pkg::*;

   entry_type mem [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_wr.we) begin
         mem[ram_wr.addr] <= ram_wr.data;
      end
      if (ram_rd.re) begin
         rdata_ff <= mem[ram_rd.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/grow_on_collision_hash_table.sv */
// A lookup or plain insert finds its slot through the remainder unit (a mask at a
// power-of-two capacity, bit-serial otherwise) and then a memory read; a lookup at
// capacity 0 needs neither. A grow clears the new capacity (double the old, or 1 from
// 0) in the other bank, then reads each old slot and rehashes each occupied one.
// One item at a time; a held result does not block input. Reset is synchronous:
// capacity 0, bank 0, no clearing pass. A write of initial_capacity clears bank 0
// slot by slot, and no item is taken while it does.
`timescale 1ns / 1ps
`include "grow_on_collision_hash_table_macros.svh"

module grow_on_collision_hash_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gcht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gcht_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import gcht_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ICLR  = 3'd1;
   localparam logic [2:0] S_EMPTY = 3'd2;
   localparam logic [2:0] S_HMOD  = 3'd3;
   localparam logic [2:0] S_HRD   = 3'd4;
   localparam logic [2:0] S_GCLR  = 3'd5;
   localparam logic [2:0] S_WRD   = 3'd6;
   localparam logic [2:0] S_WCHK  = 3'd7;
   localparam logic [2:0] S_WMOD  = 3'd2;

   logic [3:0]        state_ff, state_in;
   logic              bank_ff, bank_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [CAP_W-1:0]  cfg_ff, cfg_in;
   logic              act_ff, act_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CAP_W-1:0]  newcap_ff, newcap_in;
   logic [CAP_W-1:0]  walk_ff, walk_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [HASH_W-1:0] wh_ff, wh_in;
   logic [VAL_W-1:0]  wv_ff, wv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   ram_wr_type  ram_wr;
   ram_rd_type  ram_rd;
   entry_type   rdata;
   mod_req_type mod_req;
   mod_rsp_type mod_rsp;

   logic              out_free;
   logic              cfg_wr;
   logic [CAP_W:0]    grow_cap;
   logic              grow_full;
   logic              hit;
   logic [CAP_W-1:0]  cfg_sat;
   logic [CAP_W-1:0]  walk_next;
   logic              fin;
   logic [2:0]        fin_status;
   logic [VAL_W-1:0]  fin_value;

   // state codes share one 4-bit vector; walk-remainder wait uses its own code
   localparam logic [3:0] C_IDLE  = {1'b0, S_IDLE};
   localparam logic [3:0] C_ICLR  = {1'b0, S_ICLR};
   localparam logic [3:0] C_EMPTY = {1'b0, S_EMPTY};
   localparam logic [3:0] C_HMOD  = {1'b0, S_HMOD};
   localparam logic [3:0] C_HRD   = {1'b0, S_HRD};
   localparam logic [3:0] C_GCLR  = {1'b0, S_GCLR};
   localparam logic [3:0] C_WRD   = {1'b0, S_WRD};
   localparam logic [3:0] C_WCHK  = {1'b0, S_WCHK};
   localparam logic [3:0] C_WMOD  = {1'b1, S_WMOD};

   gcht_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   gcht_slot_ram u_ram (
      .clock  (clock),
      .ram_wr (ram_wr),
      .ram_rd (ram_rd),
      .rdata  (rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cfg_wr    = psel && penable && pwrite && (paddr == 3'(4 * REG_INIT_CAP));
   assign grow_cap  = (cap_ff == '0) ? (CAP_W+1)'(1) : {cap_ff, 1'b0};
   assign grow_full = grow_cap > (CAP_W+1)'(MAX_ENTRIES);
   assign hit       = rdata.valid && (rdata.hash == hash_ff);
   assign cfg_sat   = (pwdata[CAP_W-1:0] > CAP_W'(MAX_ENTRIES)) ?
                      CAP_W'(MAX_ENTRIES) : pwdata[CAP_W-1:0];
   assign walk_next = walk_ff + CAP_W'(1);

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      cap_in       = cap_ff;
      cfg_in       = cfg_ff;
      act_in       = act_ff;
      hash_in      = hash_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      newcap_in    = newcap_ff;
      walk_in      = walk_ff;
      clr_in       = clr_ff;
      wh_in        = wh_ff;
      wv_in        = wv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_wr       = '0;
      ram_rd       = '0;
      mod_req      = '0;
      mod_req.dividend = hash_ff;
      mod_req.divisor  = cap_ff;
      fin          = 1'b0;
      fin_status   = ST_NOT_FOUND;
      fin_value    = '0;

      unique case (state_ff) inside
         C_IDLE: begin
            if (req_valid) begin
               act_in  = req_data.action;
               hash_in = req_data.key_hash;
               val_in  = req_data.value;
               if (cap_ff == '0) begin
                  state_in = C_EMPTY;
               end else begin
                  mod_req.start    = 1'b1;
                  mod_req.dividend = req_data.key_hash;
                  state_in         = C_HMOD;
               end
            end
         end
         C_ICLR: begin
            ram_wr.we   = 1'b1;
            ram_wr.addr = {1'b0, clr_ff};
            clr_in      = clr_ff + IDX_W'(1);
            if ({1'b0, clr_ff} == cap_ff - CAP_W'(1)) begin
               state_in = C_IDLE;
            end
         end
         C_EMPTY: begin
            if (act_ff == ACT_LOOKUP) begin
               if (out_free) begin
                  fin = 1'b1;
               end
            end else begin
               newcap_in = grow_cap[CAP_W-1:0];
               clr_in    = '0;
               state_in  = C_GCLR;
            end
         end
         C_HMOD: begin
            if (mod_rsp.done) begin
               ram_rd.re   = 1'b1;
               ram_rd.addr = {bank_ff, mod_rsp.rem};
               idx_in      = mod_rsp.rem;
               state_in    = C_HRD;
            end
         end
         C_HRD: begin
            if (act_ff == ACT_LOOKUP) begin
               if (out_free) begin
                  fin        = 1'b1;
                  fin_status = hit ? ST_FOUND : ST_NOT_FOUND;
                  fin_value  = hit ? rdata.value : '0;
               end
            end else if (rdata.valid && !hit) begin
               // collision: grow, or report full when the limit is reached
               if (grow_full) begin
                  if (out_free) begin
                     fin        = 1'b1;
                     fin_status = ST_FULL;
                  end
               end else begin
                  newcap_in = grow_cap[CAP_W-1:0];
                  clr_in    = '0;
                  state_in  = C_GCLR;
               end
            end else if (out_free) begin
               fin = 1'b1;
               if (hit) begin
                  fin_status = ST_DUPLICATE;
               end else begin
                  fin_status        = ST_INSERTED;
                  ram_wr.we         = 1'b1;
                  ram_wr.addr       = {bank_ff, idx_ff};
                  ram_wr.data.valid = 1'b1;
                  ram_wr.data.hash  = hash_ff;
                  ram_wr.data.value = val_ff;
               end
            end
         end
         C_GCLR: begin
            ram_wr.we   = 1'b1;
            ram_wr.addr = {!bank_ff, clr_ff};
            clr_in      = clr_ff + IDX_W'(1);
            if ({1'b0, clr_ff} == newcap_ff - CAP_W'(1)) begin
               walk_in = '0;
               if (cap_ff == '0) begin
                  bank_in          = !bank_ff;
                  cap_in           = newcap_ff;
                  mod_req.start    = 1'b1;
                  mod_req.divisor  = newcap_ff;
                  state_in         = C_HMOD;
               end else begin
                  state_in = C_WRD;
               end
            end
         end
         C_WRD: begin
            ram_rd.re   = 1'b1;
            ram_rd.addr = {bank_ff, walk_ff[IDX_W-1:0]};
            state_in    = C_WCHK;
         end
         C_WCHK, C_WMOD: begin
            if (state_ff == C_WCHK && rdata.valid) begin
               mod_req.start    = 1'b1;
               mod_req.dividend = rdata.hash;
               mod_req.divisor  = newcap_ff;
               wh_in            = rdata.hash;
               wv_in            = rdata.value;
               state_in         = C_WMOD;
            end else if (state_ff == C_WCHK || mod_rsp.done) begin
               if (state_ff == C_WMOD) begin
                  ram_wr.we         = 1'b1;
                  ram_wr.addr       = {!bank_ff, mod_rsp.rem};
                  ram_wr.data.valid = 1'b1;
                  ram_wr.data.hash  = wh_ff;
                  ram_wr.data.value = wv_ff;
               end
               walk_in = walk_next;
               if (walk_next == cap_ff) begin
                  // walk done: swap banks and retry the insert
                  bank_in         = !bank_ff;
                  cap_in          = newcap_ff;
                  mod_req.start   = 1'b1;
                  mod_req.divisor = newcap_ff;
                  state_in        = C_HMOD;
               end else begin
                  state_in = C_WRD;
               end
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase

      if (fin) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = fin_status;
         rsp_in.value_out     = fin_value;
         rsp_in.capacity_now  = cap_ff;
         state_in             = C_IDLE;
      end

      if (cfg_wr) begin
         cfg_in   = pwdata[CAP_W-1:0];
         cap_in   = cfg_sat;
         bank_in  = 1'b0;
         clr_in   = '0;
         state_in = (cfg_sat == '0) ? C_IDLE : C_ICLR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         bank_ff      <= 1'b0;
         cap_ff       <= '0;
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         cap_ff       <= cap_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff    <= act_in;
      hash_ff   <= hash_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      newcap_ff <= newcap_in;
      walk_ff   <= walk_in;
      clr_ff    <= clr_in;
      wh_ff     <= wh_in;
      wv_ff     <= wv_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = (state_ff == C_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr == 3'(4 * REG_INIT_CAP)) ? {{(32-CAP_W){1'b0}}, cfg_ff} : '0;

   `GCHT_ASSERT_IMP(a_cap_limit, 1'b1, cap_ff <= CAP_W'(MAX_ENTRIES), "capacity above limit")
   `GCHT_ASSERT_IMP(a_walk_dst, (state_ff == C_WMOD) && ram_wr.we, ram_wr.addr[IDX_W] != bank_ff, "rehash wrote active bank")
   `GCHT_ASSERT_IMP(a_vout_zero, rsp_valid_ff && (rsp_ff.status != ST_FOUND), rsp_ff.value_out == '0, "value_out set without hit")
   `GCHT_ASSERT_NXT(a_grow_cap, (state_ff == C_GCLR) && (state_in == C_HMOD), cap_ff != '0, "grow left capacity zero")

endmodule

/* tb/grow_on_collision_hash_table_checker.sv */
// Checker for the grow-on-collision hash table: watches the request, result and
// register ports, predicts each result and compares it. Depends on gcht_pkg.
`timescale 1ns / 1ps

module grow_on_collision_hash_table_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  gcht_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  gcht_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output int                mismatch_count,
   output int                pending_count
);
   import gcht_pkg::*;

   bit                slot_used [2][MAX_ENTRIES];
   logic [HASH_W-1:0] slot_key  [2][MAX_ENTRIES];
   logic [VAL_W-1:0]  slot_data [2][MAX_ENTRIES];
   int unsigned       bank;
   int unsigned       cap;
   rsp_type           expected_rsp_q[$];

   initial mismatch_count = 0;
   assign pending_count = expected_rsp_q.size();

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic void clear_table(input int unsigned new_cap);
      foreach (slot_used[b, i]) slot_used[b][i] = 0;
      bank = 0;
      cap  = new_cap;
   endfunction

   // rehash every live entry, in old-index order, into the cleared other bank
   function automatic void grow_table(input int unsigned new_cap);
      int unsigned dst;
      int unsigned j;
      dst = bank ^ 1;
      for (int i = 0; i < MAX_ENTRIES; i++) slot_used[dst][i] = 0;
      for (int i = 0; i < cap; i++) begin
         if (slot_used[bank][i]) begin
            j = slot_key[bank][i] % new_cap;
            slot_used[dst][j] = 1;
            slot_key[dst][j]  = slot_key[bank][i];
            slot_data[dst][j] = slot_data[bank][i];
         end
      end
      bank = dst;
      cap  = new_cap;
   endfunction

   function automatic rsp_type apply_request(input req_type r);
      rsp_type     res;
      int unsigned idx;
      int unsigned next_cap;
      bit          settled;
      res.status    = ST_NOT_FOUND;
      res.value_out = '0;
      if (r.action == ACT_LOOKUP) begin
         if (cap != 0) begin
            idx = r.key_hash % cap;
            if (slot_used[bank][idx] && slot_key[bank][idx] == r.key_hash) begin
               res.status    = ST_FOUND;
               res.value_out = slot_data[bank][idx];
            end
         end
      end else begin
         settled = 0;
         while (!settled) begin
            if (cap != 0) begin
               idx = r.key_hash % cap;
               if (!slot_used[bank][idx]) begin
                  slot_used[bank][idx] = 1;
                  slot_key[bank][idx]  = r.key_hash;
                  slot_data[bank][idx] = r.value;
                  res.status = ST_INSERTED;
                  settled = 1;
               end else if (slot_key[bank][idx] == r.key_hash) begin
                  res.status = ST_DUPLICATE;
                  settled = 1;
               end
            end
            if (!settled) begin
               next_cap = (cap == 0) ? 1 : cap * 2;
               if (next_cap > MAX_ENTRIES) begin
                  res.status = ST_FULL;
                  settled = 1;
               end else begin
                  grow_table(next_cap);
               end
            end
         end
      end
      res.capacity_now = cap[CAP_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      int unsigned v;
      if (reset) begin
         clear_table(0);
         expected_rsp_q.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_INIT_CAP)) begin
            v = pwdata[CAP_W-1:0];
            clear_table(v > MAX_ENTRIES ? MAX_ENTRIES : v);
         end
         if (req_valid && req_ready)
            expected_rsp_q.push_back(apply_request(req_data));
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_rsp_q.size() == 0) begin
               report($sformatf("unexpected result status=%0d", got.status));
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.status !== want.status)
                  report($sformatf("status %0d, want %0d", got.status, want.status));
               if (got.value_out !== want.value_out)
                  report($sformatf("value_out %h, want %h", got.value_out, want.value_out));
               if (got.capacity_now !== want.capacity_now)
                  report($sformatf("capacity_now %0d, want %0d",
                                   got.capacity_now, want.capacity_now));
            end
         end
      end
   end

endmodule

/* tb/grow_on_collision_hash_table_tb.sv */
// Top of the hash table testbench: clock, reset, request and register stimulus,
// result back-pressure and verdict. Depends on gcht_pkg, the block and its checker.
`timescale 1ns / 1ps

module grow_on_collision_hash_table_tb;
   import gcht_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int          mismatch_count;
   int          pending_count;
   logic        req_took = 0;
   bit          gaps_on = 1;
   bit          hold_off_go = 0;
   logic [31:0] key_pool[$];

   always #1 clock = ~clock;

   grow_on_collision_hash_table dut (.*);

   grow_on_collision_hash_table_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .mismatch_count, .pending_count
   );

   // remember whether the request transfer happened at the last rising edge
   always @(posedge clock) begin
      req_took <= req_valid && req_ready;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_go) begin
            hold_off_go = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 0;
         end else begin
            rsp_ready = gaps_on ? ($urandom_range(99) >= 37) : 1'b1;
         end
      end
   end

   task automatic send_req(input logic act, input logic [31:0] h, input logic [31:0] v);
      while (gaps_on && $urandom_range(99) < 37) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_data.action   = act;
      req_data.key_hash = h;
      req_data.value    = v;
      do @(negedge clock); while (!req_took);
      req_valid = 0;
      if (act == ACT_INSERT) key_pool.push_back(h);
   endtask

   task automatic write_capacity(input logic [31:0] v);
      psel = 1; pwrite = 1; penable = 0;
      paddr  = 3'(4 * REG_INIT_CAP);
      pwdata = v;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
      key_pool.delete();
   endtask

   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 55 && key_pool.size() > 0)
         return key_pool[$urandom_range(key_pool.size() - 1)];
      else if (r < 80)
         return $urandom_range(63);
      else
         return $urandom;
   endfunction

   initial begin
      int unsigned caps[13] = '{0, 1, 2, 3, 7, 1024, 2047, 16, 100, 5, 0, 1, 0};
      logic [31:0] v;
      repeat (10) @(negedge clock);
      reset = 0;

      // directed: empty table, first grow, duplicate, collision grow, extremes
      send_req(ACT_LOOKUP, 32'd9, 32'hFFFF_FFFF);
      send_req(ACT_INSERT, 32'd0, 32'hFFFF_FFFF);
      send_req(ACT_INSERT, 32'd0, 32'h1234_5678);
      send_req(ACT_LOOKUP, 32'd0, 32'd0);
      send_req(ACT_INSERT, 32'hFFFF_FFFF, 32'd0);
      send_req(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hAAAA_5555);
      send_req(ACT_INSERT, 32'd2, 32'h5555_AAAA);
      send_req(ACT_LOOKUP, 32'd6, 32'd0);
      send_req(ACT_LOOKUP, 32'd2, 32'd0);
      drain();
      // full table: two hashes landing on one slot at maximum capacity
      write_capacity(32'd1024);
      send_req(ACT_INSERT, 32'd5, 32'd77);
      send_req(ACT_INSERT, 32'd1029, 32'd88);
      send_req(ACT_LOOKUP, 32'd1029, 32'd0);
      send_req(ACT_LOOKUP, 32'd5, 32'd0);
      drain();
      write_capacity(32'hFFFF_FFFF);
      send_req(ACT_INSERT, 32'd3, 32'd1);
      send_req(ACT_LOOKUP, 32'd3, 32'd0);
      drain();

      for (int ph = 0; ph < 13; ph++) begin
         write_capacity(ph == 12 ? $urandom_range(2047) : caps[ph]);
         gaps_on = (ph != 5);
         for (int n = 0; n < 92; n++) begin
            if (ph == 3 && n == 10) hold_off_go = 1;
            v = ($urandom_range(9) == 0) ? {32{$urandom_range(1) == 1}} : $urandom;
            send_req($urandom_range(1), pick_key(), v);
         end
         drain();
      end
      gaps_on = 1;

      if (mismatch_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
